>>> sv/bts_pkg.sv
`timescale 1ns / 1ps
package bts_pkg;

	// defaults for the top-level parameters
	localparam int MAX_WIDTH_DEF       = 256;
	localparam int MAX_HEIGHT_DEF      = 256;
	localparam int CHANNEL_BITS_DEF    = 16;
	localparam int COORD_FRAC_BITS_DEF = 16;

	// fixed port widths
	localparam int CFG_DATA_W   = 9;
	localparam int POS_PORT_W   = 8;
	localparam int CHAN_PORT_W  = 16;
	localparam int COORD_PORT_W = 17;

	localparam int SIZE_RESET = 256;
	localparam int NUM_CH     = 3;

	// default bank geometry for the generic RAM
	localparam int RAM_WIDTH_DEF = NUM_CH * CHANNEL_BITS_DEF;
	localparam int RAM_DEPTH_DEF = ((MAX_WIDTH_DEF + 1) / 2) * ((MAX_HEIGHT_DEF + 1) / 2);

	typedef enum logic {
		REG_WIDTH_IN_USE,
		REG_HEIGHT_IN_USE
	} cfg_reg_t;

	typedef enum logic {
		FUNC_WRITE,
		FUNC_SAMPLE
	} func_t;

	// which parity bank holds the base tap, and whether the +1 neighbor folded back
	typedef struct packed {
		logic col_par;
		logic row_par;
		logic col_clamp;
		logic row_clamp;
	} tap_sel_t;

endpackage

>>> sv/bts_ram.sv
`timescale 1ns / 1ps
module bts_ram #(
	parameter int WIDTH = bts_pkg::RAM_WIDTH_DEF,
	parameter int DEPTH = bts_pkg::RAM_DEPTH_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> sv/bts_coord.sv
`timescale 1ns / 1ps
module bts_coord #(
	parameter int MAX_WIDTH       = bts_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT      = bts_pkg::MAX_HEIGHT_DEF,
	parameter int COORD_FRAC_BITS = bts_pkg::COORD_FRAC_BITS_DEF,
	localparam int IX_W = $clog2(MAX_WIDTH),
	localparam int IY_W = $clog2(MAX_HEIGHT),
	localparam int F    = COORD_FRAC_BITS
) (
	input  logic                              clk,
	input  logic                              en,
	input  logic [bts_pkg::COORD_PORT_W-1:0]  u_coord,
	input  logic [bts_pkg::COORD_PORT_W-1:0]  v_coord,
	input  logic [IX_W-1:0]                   w_m1,
	input  logic [IY_W-1:0]                   h_m1,
	output logic [IX_W-1:0]                   i0,
	output logic [IX_W-1:0]                   i1,
	output logic [IY_W-1:0]                   j0,
	output logic [IY_W-1:0]                   j1,
	output logic [F-1:0]                      fu,
	output logic [F-1:0]                      fv,
	output bts_pkg::tap_sel_t                 sel
);

	localparam int DU_W = IX_W + F;
	localparam int DV_W = IY_W + F;
	localparam logic [bts_pkg::COORD_PORT_W-1:0] COORD_ONE =
		bts_pkg::COORD_PORT_W'(2 ** F);

	logic [bts_pkg::COORD_PORT_W-1:0] u_sat, v_sat;
	logic [F:0]                       cu, cv;
	logic [DU_W-1:0]                  du_s1;
	logic [DV_W-1:0]                  dv_s1;

	// saturate to 1.0, then scale by size-1
	assign u_sat = (u_coord > COORD_ONE) ? COORD_ONE : u_coord;
	assign v_sat = (v_coord > COORD_ONE) ? COORD_ONE : v_coord;
	assign cu    = u_sat[F:0];
	assign cv    = v_sat[F:0];

	always_ff @(posedge clk) begin
		if (en) begin
			du_s1 <= DU_W'(w_m1) * DU_W'(cu);
			dv_s1 <= DV_W'(h_m1) * DV_W'(cv);
		end
	end

	assign i0 = du_s1[F +: IX_W];
	assign j0 = dv_s1[F +: IY_W];
	assign fu = du_s1[F-1:0];
	assign fv = dv_s1[F-1:0];

	// right/bottom neighbor folds back onto the last column/row
	assign sel.col_clamp = (i0 == w_m1);
	assign sel.row_clamp = (j0 == h_m1);
	assign sel.col_par   = i0[0];
	assign sel.row_par   = j0[0];
	assign i1 = sel.col_clamp ? i0 : i0 + IX_W'(1);
	assign j1 = sel.row_clamp ? j0 : j0 + IY_W'(1);

endmodule

>>> sv/bts_store.sv
`timescale 1ns / 1ps
module bts_store #(
	parameter int MAX_WIDTH    = bts_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT   = bts_pkg::MAX_HEIGHT_DEF,
	parameter int CHANNEL_BITS = bts_pkg::CHANNEL_BITS_DEF,
	localparam int IX_W = $clog2(MAX_WIDTH),
	localparam int IY_W = $clog2(MAX_HEIGHT),
	localparam int CB   = CHANNEL_BITS,
	localparam int NCH  = bts_pkg::NUM_CH
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    wr_en,
	input  logic [IX_W-1:0]         wr_col,
	input  logic [IY_W-1:0]         wr_row,
	input  logic [NCH-1:0][CB-1:0]  wr_texel,
	input  logic                    rd_en,
	input  logic [IX_W-1:0]         i0,
	input  logic [IX_W-1:0]         i1,
	input  logic [IY_W-1:0]         j0,
	input  logic [IY_W-1:0]         j1,
	input  bts_pkg::tap_sel_t       sel,
	output logic [NCH-1:0][CB-1:0]  c00,
	output logic [NCH-1:0][CB-1:0]  c10,
	output logic [NCH-1:0][CB-1:0]  c01,
	output logic [NCH-1:0][CB-1:0]  c11
);

	localparam int HALF_W     = (MAX_WIDTH + 1) / 2;
	localparam int HALF_H     = (MAX_HEIGHT + 1) / 2;
	localparam int BANK_DEPTH = HALF_W * HALF_H;
	localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
	localparam int TW         = NCH * CB;

	logic [3:0][TW-1:0]  q;
	bts_pkg::tap_sel_t   sel_s2;
	logic                ic_s2, jr_s2;

	// four banks split on column/row parity: bank index = {row[0], col[0]}
	for (genvar b = 0; b < 4; b++) begin : g_bank
		localparam logic CP = 1'(b % 2);
		localparam logic RP = 1'(b / 2);

		logic [IX_W-1:0]    rcol;
		logic [IY_W-1:0]    rrow;
		logic [31:0]        rd_a32, wr_a32;
		logic               bank_we;

		assign rcol    = (CP == sel.col_par) ? i0 : i1;
		assign rrow    = (RP == sel.row_par) ? j0 : j1;
		assign rd_a32  = 32'(rrow >> 1) * 32'(HALF_W) + 32'(rcol >> 1);
		assign wr_a32  = 32'(wr_row >> 1) * 32'(HALF_W) + 32'(wr_col >> 1);
		assign bank_we = wr_en && (wr_col[0] == CP) && (wr_row[0] == RP);

		bts_ram #(
			.WIDTH(TW),
			.DEPTH(BANK_DEPTH)
		) u_ram (
			.clk   (clk),
			.we    (bank_we),
			.waddr (wr_a32[BANK_AW-1:0]),
			.wdata (TW'(wr_texel)),
			.re    (rd_en),
			.raddr (rd_a32[BANK_AW-1:0]),
			.rdata (q[b])
		);
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			sel_s2 <= sel;
		end
	end

	// clamped neighbor reuses the base tap's bank
	assign ic_s2 = sel_s2.col_clamp ? sel_s2.col_par : ~sel_s2.col_par;
	assign jr_s2 = sel_s2.row_clamp ? sel_s2.row_par : ~sel_s2.row_par;

	assign c00 = q[{sel_s2.row_par, sel_s2.col_par}];
	assign c10 = q[{sel_s2.row_par, ic_s2}];
	assign c01 = q[{jr_s2, sel_s2.col_par}];
	assign c11 = q[{jr_s2, ic_s2}];

	a_rd_wr_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> !wr_en)
		else $error("store read and write issued for the same slot");

endmodule

>>> sv/bts_lerp.sv
`timescale 1ns / 1ps
module bts_lerp #(
	parameter int CHANNEL_BITS    = bts_pkg::CHANNEL_BITS_DEF,
	parameter int COORD_FRAC_BITS = bts_pkg::COORD_FRAC_BITS_DEF,
	localparam int CB  = CHANNEL_BITS,
	localparam int F   = COORD_FRAC_BITS,
	localparam int NCH = bts_pkg::NUM_CH
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic [NCH-1:0][CB-1:0]  c00,
	input  logic [NCH-1:0][CB-1:0]  c10,
	input  logic [NCH-1:0][CB-1:0]  c01,
	input  logic [NCH-1:0][CB-1:0]  c11,
	input  logic [F-1:0]            fu,
	input  logic [F-1:0]            fv,
	output logic [NCH-1:0][CB-1:0]  result
);

	localparam int TOP_W = CB + F;
	localparam int SUM_W = CB + 2 * F;
	localparam int WGT_W = F + 1;
	localparam logic [WGT_W-1:0] ONE = WGT_W'(2 ** F);

	logic [WGT_W-1:0]             wu0, wv0;
	logic [F-1:0]                 fv_s3;
	logic [NCH-1:0][TOP_W-1:0]    top_d, bot_d, top_s3, bot_s3;
	logic [NCH-1:0][SUM_W-1:0]    sum_d, sum_s4;

	assign wu0 = ONE - WGT_W'(fu);
	assign wv0 = ONE - WGT_W'(fv_s3);

	// horizontal blend
	always_comb begin
		for (int ch = 0; ch < NCH; ch++) begin
			top_d[ch] = TOP_W'(c00[ch]) * TOP_W'(wu0) + TOP_W'(c10[ch]) * TOP_W'(fu);
			bot_d[ch] = TOP_W'(c01[ch]) * TOP_W'(wu0) + TOP_W'(c11[ch]) * TOP_W'(fu);
		end
	end

	// vertical blend
	always_comb begin
		for (int ch = 0; ch < NCH; ch++) begin
			sum_d[ch] = SUM_W'(top_s3[ch]) * SUM_W'(wv0)
				+ SUM_W'(bot_s3[ch]) * SUM_W'(fv_s3);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			top_s3 <= top_d;
			bot_s3 <= bot_d;
			fv_s3  <= fv;
			sum_s4 <= sum_d;
		end
	end

	always_comb begin
		for (int ch = 0; ch < NCH; ch++) begin
			result[ch] = sum_s4[ch][2 * F +: CB];
		end
	end

endmodule

>>> sv/bilinear_texture_sampler_core.sv
`timescale 1ns / 1ps
// channel  | handshake           | payload
// ---------+---------------------+------------------------------------------------
// in       | in_valid / in_stall | func, texel_column, texel_row, texel_red,
//          |                     | texel_green, texel_blue, u_coord, v_coord
// out      | out_valid/out_stall | sample_red, sample_green, sample_blue
// cfg      | cfg_we              | cfg_index, cfg_data (write only)
//
// One word per cycle in and out while no stall holds the pipe. A sample goes in order
// through the stages (s1 coord scale, s2 parity-banked texel read, s3 horizontal, s4 vertical blend).
// A texel write retires after s1, where it goes into its bank; it gives no word.
// in_stall rises only while a finished sample sits in s4 and out is stalled;
// then every stage holds. Reset clears valid bits and the size registers (256);
// the texture store is not cleared and a texel is defined once written.
module bilinear_texture_sampler_core #(
	parameter int MAX_WIDTH       = bts_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT      = bts_pkg::MAX_HEIGHT_DEF,
	parameter int CHANNEL_BITS    = bts_pkg::CHANNEL_BITS_DEF,
	parameter int COORD_FRAC_BITS = bts_pkg::COORD_FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// config
	input  logic                               cfg_we,
	input  logic                               cfg_index,
	input  logic [bts_pkg::CFG_DATA_W-1:0]     cfg_data,
	// request
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               func,
	input  logic [bts_pkg::POS_PORT_W-1:0]     texel_column,
	input  logic [bts_pkg::POS_PORT_W-1:0]     texel_row,
	input  logic [bts_pkg::CHAN_PORT_W-1:0]    texel_red,
	input  logic [bts_pkg::CHAN_PORT_W-1:0]    texel_green,
	input  logic [bts_pkg::CHAN_PORT_W-1:0]    texel_blue,
	input  logic [bts_pkg::COORD_PORT_W-1:0]   u_coord,
	input  logic [bts_pkg::COORD_PORT_W-1:0]   v_coord,
	// result
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [bts_pkg::CHAN_PORT_W-1:0]    sample_red,
	output logic [bts_pkg::CHAN_PORT_W-1:0]    sample_green,
	output logic [bts_pkg::CHAN_PORT_W-1:0]    sample_blue
);

	localparam int IX_W = $clog2(MAX_WIDTH);
	localparam int IY_W = $clog2(MAX_HEIGHT);
	localparam int CB   = CHANNEL_BITS;
	localparam int F    = COORD_FRAC_BITS;
	localparam int NCH  = bts_pkg::NUM_CH;

	// size registers
	logic [bts_pkg::CFG_DATA_W-1:0] width_q, height_q;
	logic [31:0]                    w_eff, h_eff;
	logic [IX_W-1:0]                w_m1;
	logic [IY_W-1:0]                h_m1;

	// pipeline control
	logic en;
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic sample_s1, wr_ok_s1;
	logic wr_en, rd_en;

	// write payload at s1
	logic [31:0]               col32, row32;
	logic [IX_W-1:0]           col_s1;
	logic [IY_W-1:0]           row_s1;
	logic [NCH-1:0][CB-1:0]    texel_s1;

	// coord split at s1, fractions at s2
	logic [IX_W-1:0]           i0, i1;
	logic [IY_W-1:0]           j0, j1;
	logic [F-1:0]              fu, fv, fu_s2, fv_s2;
	bts_pkg::tap_sel_t         sel;

	logic [NCH-1:0][CB-1:0]    c00, c10, c01, c11, result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= bts_pkg::CFG_DATA_W'(bts_pkg::SIZE_RESET);
			height_q <= bts_pkg::CFG_DATA_W'(bts_pkg::SIZE_RESET);
		end else if (cfg_we) begin
			unique case (bts_pkg::cfg_reg_t'(cfg_index))
				bts_pkg::REG_WIDTH_IN_USE:  width_q  <= cfg_data;
				bts_pkg::REG_HEIGHT_IN_USE: height_q <= cfg_data;
			endcase
		end
	end

	// clamp sizes into [2, MAX]
	always_comb begin
		if (32'(width_q) < 32'd2) begin
			w_eff = 32'd2;
		end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
			w_eff = 32'(MAX_WIDTH);
		end else begin
			w_eff = 32'(width_q);
		end
		if (32'(height_q) < 32'd2) begin
			h_eff = 32'd2;
		end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
			h_eff = 32'(MAX_HEIGHT);
		end else begin
			h_eff = 32'(height_q);
		end
	end

	assign w_m1 = IX_W'(w_eff - 32'd1);
	assign h_m1 = IY_W'(h_eff - 32'd1);

	// whole pipe advances together; only a blocked output word holds it
	assign en       = !(valid_s4 && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1 && sample_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	assign col32 = 32'(texel_column);
	assign row32 = 32'(texel_row);

	always_ff @(posedge clk) begin
		if (en) begin
			sample_s1   <= (func == bts_pkg::FUNC_SAMPLE);
			wr_ok_s1    <= (col32 < 32'(MAX_WIDTH)) && (row32 < 32'(MAX_HEIGHT));
			col_s1      <= col32[IX_W-1:0];
			row_s1      <= row32[IY_W-1:0];
			texel_s1[0] <= texel_red[CB-1:0];
			texel_s1[1] <= texel_green[CB-1:0];
			texel_s1[2] <= texel_blue[CB-1:0];
			fu_s2       <= fu;
			fv_s2       <= fv;
		end
	end

	assign wr_en = en && valid_s1 && !sample_s1 && wr_ok_s1;
	assign rd_en = en && valid_s1 && sample_s1;

	bts_coord #(
		.MAX_WIDTH       (MAX_WIDTH),
		.MAX_HEIGHT      (MAX_HEIGHT),
		.COORD_FRAC_BITS (COORD_FRAC_BITS)
	) u_coord_split (
		.clk     (clk),
		.en      (en),
		.u_coord (u_coord),
		.v_coord (v_coord),
		.w_m1    (w_m1),
		.h_m1    (h_m1),
		.i0      (i0),
		.i1      (i1),
		.j0      (j0),
		.j1      (j1),
		.fu      (fu),
		.fv      (fv),
		.sel     (sel)
	);

	bts_store #(
		.MAX_WIDTH    (MAX_WIDTH),
		.MAX_HEIGHT   (MAX_HEIGHT),
		.CHANNEL_BITS (CHANNEL_BITS)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_col   (col_s1),
		.wr_row   (row_s1),
		.wr_texel (texel_s1),
		.rd_en    (rd_en),
		.i0       (i0),
		.i1       (i1),
		.j0       (j0),
		.j1       (j1),
		.sel      (sel),
		.c00      (c00),
		.c10      (c10),
		.c01      (c01),
		.c11      (c11)
	);

	bts_lerp #(
		.CHANNEL_BITS    (CHANNEL_BITS),
		.COORD_FRAC_BITS (COORD_FRAC_BITS)
	) u_lerp (
		.clk    (clk),
		.en     (en),
		.c00    (c00),
		.c10    (c10),
		.c01    (c01),
		.c11    (c11),
		.fu     (fu_s2),
		.fv     (fv_s2),
		.result (result)
	);

	assign out_valid    = valid_s4;
	assign sample_red   = bts_pkg::CHAN_PORT_W'(result[0]);
	assign sample_green = bts_pkg::CHAN_PORT_W'(result[1]);
	assign sample_blue  = bts_pkg::CHAN_PORT_W'(result[2]);

	// a texel write never turns into an output word
	a_write_retires: assert property (@(posedge clk) disable iff (!arst_n)
		(en && valid_s1 && !sample_s1) |=> !valid_s2)
		else $error("texel write leaked past s1");

	// a held pipe keeps every valid bit
	a_hold_valids: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable({valid_s1, valid_s2, valid_s3, valid_s4}))
		else $error("valid bit moved while pipe was held");

	// input backpressure only from a blocked finished word
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("in_stall without a blocked output word");

	// a sample in s3 reaches the output register when the pipe moves
	a_s3_to_s4: assert property (@(posedge clk) disable iff (!arst_n)
		(en && valid_s3) |=> valid_s4)
		else $error("sample lost between s3 and s4");

endmodule

>>> sim/bilinear_texture_sampler_core_test.sv
`timescale 1ns / 1ps
// Bilinear sampler bench: texel writes and sample requests go in as words on the
// request channel. Sample words come back on the result channel. A local blend
// model keeps its own copy of the texture and the size registers, and it queues the
// colour that each accepted sample must return.
module bilinear_texture_sampler_core_test;

	localparam int COORD_FRAC_BITS_DEF = bts_pkg::COORD_FRAC_BITS_DEF;
	localparam int MAX_WIDTH_DEF       = bts_pkg::MAX_WIDTH_DEF;
	localparam int MAX_HEIGHT_DEF      = bts_pkg::MAX_HEIGHT_DEF;
	localparam int CFG_DATA_W          = bts_pkg::CFG_DATA_W;
	localparam int POS_PORT_W          = bts_pkg::POS_PORT_W;
	localparam int CHAN_PORT_W         = bts_pkg::CHAN_PORT_W;
	localparam int COORD_PORT_W        = bts_pkg::COORD_PORT_W;
	localparam int SIZE_RESET          = bts_pkg::SIZE_RESET;

	localparam int CYCLE_LIMIT   = 300000;
	localparam int SETTLE_CYCLES = 8;     // 4-stage pipe plus margin
	localparam int RANDOM_WORDS  = 320;   // request words per size setting
	localparam longint unsigned ONE = longint'(1) << COORD_FRAC_BITS_DEF;

	typedef struct packed {
		logic [CHAN_PORT_W-1:0] red;
		logic [CHAN_PORT_W-1:0] green;
		logic [CHAN_PORT_W-1:0] blue;
	} pixel_t;

	// one request word; typed=1 carries a hand-written colour for the sample
	typedef struct packed {
		bts_pkg::func_t          op;
		logic [POS_PORT_W-1:0]   col;
		logic [POS_PORT_W-1:0]   row;
		logic [CHAN_PORT_W-1:0]  red;
		logic [CHAN_PORT_W-1:0]  green;
		logic [CHAN_PORT_W-1:0]  blue;
		logic [COORD_PORT_W-1:0] u;
		logic [COORD_PORT_W-1:0] v;
		logic                    typed;
		pixel_t                  want;
	} req_word_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_we = 1'b0;
	logic                     cfg_index = 1'b0;
	logic [CFG_DATA_W-1:0]    cfg_data = '0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic                     func = 1'b0;
	logic [POS_PORT_W-1:0]    texel_column = '0;
	logic [POS_PORT_W-1:0]    texel_row = '0;
	logic [CHAN_PORT_W-1:0]   texel_red = '0;
	logic [CHAN_PORT_W-1:0]   texel_green = '0;
	logic [CHAN_PORT_W-1:0]   texel_blue = '0;
	logic [COORD_PORT_W-1:0]  u_coord = '0;
	logic [COORD_PORT_W-1:0]  v_coord = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic [CHAN_PORT_W-1:0]   sample_red;
	logic [CHAN_PORT_W-1:0]   sample_green;
	logic [CHAN_PORT_W-1:0]   sample_blue;

	// blend model state
	pixel_t            texels [0:MAX_WIDTH_DEF*MAX_HEIGHT_DEF-1];
	bit                texel_known [0:MAX_WIDTH_DEF*MAX_HEIGHT_DEF-1];
	logic [CFG_DATA_W-1:0] width_reg = CFG_DATA_W'(SIZE_RESET);
	logic [CFG_DATA_W-1:0] height_reg = CFG_DATA_W'(SIZE_RESET);
	pixel_t            pending_samples [$];

	int                fail_count = 0;
	logic [31:0]       cycles = '0;
	int                send_idle_pct = 0;
	int                recv_idle_pct = 0;
	req_word_t         dir_rows [0:15];

	// while bits 9:8 of the cycle counter are both set, neither side idles
	wire calm = (cycles[9:8] == 2'b11);

	bilinear_texture_sampler_core u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.func        (func),
		.texel_column(texel_column),
		.texel_row   (texel_row),
		.texel_red   (texel_red),
		.texel_green (texel_green),
		.texel_blue  (texel_blue),
		.u_coord     (u_coord),
		.v_coord     (v_coord),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.sample_red  (sample_red),
		.sample_green(sample_green),
		.sample_blue (sample_blue)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// ---------------------------------------------------------------- blend model

	// size register as the block sees it: below 2 acts as 2, above max acts as max
	function automatic int unsigned eff_size(logic [CFG_DATA_W-1:0] r, int unsigned top);
		if (r < 2) return 2;
		if (r > top) return top;
		return r;
	endfunction

	// scale a coordinate (saturated at 1.0) into base index, clamped neighbor, fraction
	function automatic void split_axis(input logic [COORD_PORT_W-1:0] coord,
			input int unsigned size, output int unsigned lo, output int unsigned hi,
			output int unsigned frac);
		longint unsigned c;
		longint unsigned d;
		c = (coord > ONE) ? ONE : longint'(coord);
		d = longint'(size - 1) * c;
		lo = int'(d >> COORD_FRAC_BITS_DEF);
		if (lo > size - 1) lo = size - 1;
		hi = (lo + 1 > size - 1) ? size - 1 : lo + 1;
		frac = int'(d & (ONE - 1));
	endfunction

	// exact weighted sum, truncated back to Q0.16
	function automatic logic [CHAN_PORT_W-1:0] mix_channel(longint unsigned a00,
			longint unsigned a10, longint unsigned a01, longint unsigned a11,
			longint unsigned fu, longint unsigned fv);
		longint unsigned top_row;
		longint unsigned bot_row;
		longint unsigned acc;
		top_row = a00 * (ONE - fu) + a10 * fu;
		bot_row = a01 * (ONE - fu) + a11 * fu;
		acc = top_row * (ONE - fv) + bot_row * fv;
		return CHAN_PORT_W'(acc >> (2 * COORD_FRAC_BITS_DEF));
	endfunction

	function automatic pixel_t blend_sample(logic [COORD_PORT_W-1:0] u,
			logic [COORD_PORT_W-1:0] v);
		int unsigned i0, i1, fu, j0, j1, fv;
		pixel_t c00, c10, c01, c11, res;
		split_axis(u, eff_size(width_reg, MAX_WIDTH_DEF), i0, i1, fu);
		split_axis(v, eff_size(height_reg, MAX_HEIGHT_DEF), j0, j1, fv);
		c00 = texels[j0 * MAX_WIDTH_DEF + i0];
		c10 = texels[j0 * MAX_WIDTH_DEF + i1];
		c01 = texels[j1 * MAX_WIDTH_DEF + i0];
		c11 = texels[j1 * MAX_WIDTH_DEF + i1];
		res.red   = mix_channel(c00.red, c10.red, c01.red, c11.red, fu, fv);
		res.green = mix_channel(c00.green, c10.green, c01.green, c11.green, fu, fv);
		res.blue  = mix_channel(c00.blue, c10.blue, c01.blue, c11.blue, fu, fv);
		return res;
	endfunction

	// model update at the edge where the word is taken
	task automatic apply_word(input req_word_t w);
		if (w.op == bts_pkg::FUNC_WRITE) begin
			texels[{w.row, w.col}] = '{w.red, w.green, w.blue};
			texel_known[{w.row, w.col}] = 1'b1;
		end else if (w.typed) begin
			pending_samples = {pending_samples, w.want};
		end else begin
			pending_samples = {pending_samples, blend_sample(w.u, w.v)};
		end
	endtask

	// ---------------------------------------------------------------- word builders

	function automatic req_word_t texel_wr(logic [POS_PORT_W-1:0] col,
			logic [POS_PORT_W-1:0] row, logic [CHAN_PORT_W-1:0] r,
			logic [CHAN_PORT_W-1:0] g, logic [CHAN_PORT_W-1:0] b);
		req_word_t s;
		s = '0;
		s.op = bts_pkg::FUNC_WRITE;
		s.col = col;
		s.row = row;
		s.red = r;
		s.green = g;
		s.blue = b;
		// junk in the unused coordinate fields
		s.u = COORD_PORT_W'($urandom);
		s.v = COORD_PORT_W'($urandom);
		return s;
	endfunction

	function automatic req_word_t sample_rq(logic [COORD_PORT_W-1:0] u,
			logic [COORD_PORT_W-1:0] v);
		req_word_t s;
		s = '0;
		s.op = bts_pkg::FUNC_SAMPLE;
		s.u = u;
		s.v = v;
		// junk in the unused texel fields
		s.col = POS_PORT_W'($urandom);
		s.row = POS_PORT_W'($urandom);
		s.red = CHAN_PORT_W'($urandom);
		s.green = CHAN_PORT_W'($urandom);
		s.blue = CHAN_PORT_W'($urandom);
		return s;
	endfunction

	function automatic req_word_t sample_known(logic [COORD_PORT_W-1:0] u,
			logic [COORD_PORT_W-1:0] v, logic [CHAN_PORT_W-1:0] r,
			logic [CHAN_PORT_W-1:0] g, logic [CHAN_PORT_W-1:0] b);
		req_word_t s;
		s = sample_rq(u, v);
		s.typed = 1'b1;
		s.want = '{r, g, b};
		return s;
	endfunction

	function automatic logic [CHAN_PORT_W-1:0] rand_chan();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return CHAN_PORT_W'($urandom_range(0, 65535));
		endcase
	endfunction

	// mostly in range, with the ends and saturating values mixed in
	function automatic logic [COORD_PORT_W-1:0] rand_coord();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return COORD_PORT_W'(ONE);
			2: return COORD_PORT_W'($urandom_range(int'(ONE) + 1, 17'h1FFFF));
			3: return COORD_PORT_W'($urandom);
			default: return COORD_PORT_W'($urandom_range(0, int'(ONE)));
		endcase
	endfunction

	// ---------------------------------------------------------------- drivers

	// Called at a falling edge; returns at the falling edge after acceptance with
	// in_valid still high, so back-to-back words need no extra NBA on in_valid.
	task automatic push_word(input req_word_t w);
		while ($urandom_range(0, 99) < send_idle_pct && !calm) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		func         <= w.op;
		texel_column <= w.col;
		texel_row    <= w.row;
		texel_red    <= w.red;
		texel_green  <= w.green;
		texel_blue   <= w.blue;
		u_coord      <= w.u;
		v_coord      <= w.v;
		do @(posedge clk); while (in_stall);
		apply_word(w);
		@(negedge clk);
	endtask

	// sender pause until every sample word is back, plus pipe flush for writes
	task automatic hold_until_empty();
		in_valid <= 1'b0;
		while (pending_samples.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_size(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
		hold_until_empty();
		cfg_we    <= 1'b1;
		cfg_index <= bts_pkg::REG_WIDTH_IN_USE;
		cfg_data  <= w;
		@(negedge clk);
		cfg_index <= bts_pkg::REG_HEIGHT_IN_USE;
		cfg_data  <= h;
		@(negedge clk);
		cfg_we    <= 1'b0;
		width_reg  = w;
		height_reg = h;
	endtask

	// Random traffic: mostly samples preceded by the writes their four taps still
	// need, so no tap is ever read unwritten; stray writes anywhere in between.
	task automatic run_random(input int budget);
		int words;
		bit drained;
		int unsigned i0, i1, fu, j0, j1, fv;
		logic [15:0] taps [4];
		logic [COORD_PORT_W-1:0] u, v;
		words = 0;
		drained = 1'b0;
		while (words < budget) begin
			if (!drained && words >= budget / 2) begin
				hold_until_empty();
				drained = 1'b1;
			end
			if ($urandom_range(0, 4) == 0) begin
				push_word(texel_wr(POS_PORT_W'($urandom_range(0, 255)),
					POS_PORT_W'($urandom_range(0, 255)), rand_chan(), rand_chan(), rand_chan()));
				words++;
			end else begin
				u = rand_coord();
				v = rand_coord();
				split_axis(u, eff_size(width_reg, MAX_WIDTH_DEF), i0, i1, fu);
				split_axis(v, eff_size(height_reg, MAX_HEIGHT_DEF), j0, j1, fv);
				taps[0] = 16'(j0 * MAX_WIDTH_DEF + i0);
				taps[1] = 16'(j0 * MAX_WIDTH_DEF + i1);
				taps[2] = 16'(j1 * MAX_WIDTH_DEF + i0);
				taps[3] = 16'(j1 * MAX_WIDTH_DEF + i1);
				// now and then force a fresh write of a tap right before its read
				if ($urandom_range(0, 5) == 0) texel_known[taps[$urandom_range(0, 3)]] = 1'b0;
				for (int k = 0; k < 4; k++) begin
					if (!texel_known[taps[k]]) begin
						push_word(texel_wr(taps[k][7:0], taps[k][15:8],
							rand_chan(), rand_chan(), rand_chan()));
						words++;
					end
				end
				push_word(sample_rq(u, v));
				words++;
				// overwrite a tap while that sample is still in the pipe
				if ($urandom_range(0, 4) == 0) begin
					i0 = $urandom_range(0, 3);
					push_word(texel_wr(taps[i0][7:0], taps[i0][15:8],
						rand_chan(), rand_chan(), rand_chan()));
					words++;
				end
			end
		end
	endtask

	// ---------------------------------------------------------------- result side

	always @(negedge clk) begin
		out_stall <= arst_n && !calm && ($urandom_range(0, 99) < recv_idle_pct);
	end

	always @(posedge clk) begin
		pixel_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_samples.size() == 0) begin
				$error("sample word with no sample pending");
				fail_count++;
			end else begin
				want = pending_samples.pop_front();
				if (sample_red !== want.red) begin
					$error("sample_red: expected %h, got %h", want.red, sample_red);
					fail_count++;
				end
				if (sample_green !== want.green) begin
					$error("sample_green: expected %h, got %h", want.green, sample_green);
					fail_count++;
				end
				if (sample_blue !== want.blue) begin
					$error("sample_blue: expected %h, got %h", want.blue, sample_blue);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		// Directed words at the reset size (256 x 256). Every sample has all four
		// taps written, zero-weight taps included.
		dir_rows = '{
			texel_wr(8'd0,   8'd0,   16'hFFFF, 16'h0000, 16'h1234),
			texel_wr(8'd1,   8'd0,   16'h0000, 16'hFFFF, 16'h0000),
			texel_wr(8'd0,   8'd1,   16'h8000, 16'h8000, 16'h8000),
			texel_wr(8'd1,   8'd1,   16'hFFFF, 16'hFFFF, 16'hFFFF),
			sample_known(17'd0, 17'd0, 16'hFFFF, 16'h0000, 16'h1234),  // zero fraction
			sample_rq(17'd128, 17'd128),                             // mixed weights
			texel_wr(8'd255, 8'd255, 16'h0001, 16'hFFFE, 16'h7FFF),
			texel_wr(8'd255, 8'd0,   16'h0000, 16'hFFFF, 16'h5A5A),
			texel_wr(8'd255, 8'd1,   16'h1111, 16'h2222, 16'h3333),
			// u = v = 1.0: neighbor clamps back onto the last texel
			sample_known(17'h10000, 17'h10000, 16'h0001, 16'hFFFE, 16'h7FFF),
			// above 1.0 saturates
			sample_known(17'h1FFFF, 17'h1FFFF, 16'h0001, 16'hFFFE, 16'h7FFF),
			sample_known(17'h10000, 17'd0, 16'h0000, 16'hFFFF, 16'h5A5A),
			sample_known(17'h1FFFF, 17'd0, 16'h0000, 16'hFFFF, 16'h5A5A),
			// overwrite then read back at once
			texel_wr(8'd0,   8'd0,   16'h0000, 16'h0000, 16'h0000),
			sample_known(17'd0, 17'd0, 16'h0000, 16'h0000, 16'h0000),
			sample_rq(17'd200, 17'd255)
		};

		send_idle_pct = 12;
		recv_idle_pct = 51;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[n]) push_word(dir_rows[n]);

		// two size settings per idle pattern; 0 and 511 probe the size clamps
		for (int step = 0; step < 6; step++) begin
			case (step / 2)
				0: begin send_idle_pct = 12; recv_idle_pct = 51; end
				1: begin send_idle_pct = 51; recv_idle_pct = 12; end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			case (step)
				0: set_size(9'd256, 9'd256);
				1: set_size(9'd2, 9'd2);
				2: set_size(9'd0, 9'd511);
				3: set_size(9'd3, 9'd5);
				4: set_size(9'd511, 9'd300);
				default: set_size(9'($urandom_range(2, 256)), 9'($urandom_range(2, 256)));
			endcase
			run_random(RANDOM_WORDS);
		end

		hold_until_empty();
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

>>> sim.f
sv/bts_pkg.sv
sv/bts_ram.sv
sv/bts_coord.sv
sv/bts_store.sv
sv/bts_lerp.sv
sv/bilinear_texture_sampler_core.sv
sim/bilinear_texture_sampler_core_test.sv
